### src/light_pulse_width_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// light pulse width classifier assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef LIGHT_PULSE_WIDTH_CLASSIFIER_TOP_ASSERT_SVH
`define LIGHT_PULSE_WIDTH_CLASSIFIER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LPWC_ASSERT_IMPLY(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPWC_ASSERT_NEXT(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`else

`define LPWC_ASSERT_IMPLY(lbl, clock, reset, ante, cons, msg)
`define LPWC_ASSERT_NEXT(lbl, clock, reset, ante, cons, msg)

`endif

`endif

### src/lpwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpwc_pkg
// types and constants shared by the light pulse width classifier
// ----------------------------------------------------------------------------
package lpwc_pkg;

  localparam int TimeWidth   = 32;
  localparam int ThreshWidth = 16;
  localparam int CfgIdxWidth = 8;
  localparam int ScaledWidth = ThreshWidth + 1;

  // register indexes on the configuration port
  typedef enum logic [CfgIdxWidth-1:0] {
    RegSyncMin  = 8'd0,
    RegSyncMax  = 8'd1,
    RegSweepMin = 8'd2,
    RegSweepMax = 8'd3
  } cfg_reg_t;

  // threshold reset values, in 40 MHz ticks
  localparam logic [ThreshWidth-1:0] SyncMinReset  = 16'd2400;
  localparam logic [ThreshWidth-1:0] SyncMaxReset  = 16'd5600;
  localparam logic [ThreshWidth-1:0] SweepMinReset = 16'd40;
  localparam logic [ThreshWidth-1:0] SweepMaxReset = 16'd800;

  // pulse kind codes
  localparam logic KindSync  = 1'b0;
  localparam logic KindSweep = 1'b1;

  // w / 5 as (w * 52429) >> 18, exact for any 16-bit w
  localparam logic [15:0] Div5Mul   = 16'd52429;
  localparam int          Div5Shift = 18;

  // sync code offset in 48 MHz ticks
  localparam logic [ScaledWidth-1:0] CodeOffset = 17'd2501;
  // below the offset the 32-bit difference wraps: 2^32 = 500 * 8589934 + 296,
  // so the quotient is 8589929 + (scaled + 295) / 500
  localparam logic [ScaledWidth-1:0] WrapBias   = 17'd295;
  localparam logic [ScaledWidth-1:0] WrapLimit  = 17'd2796;
  localparam logic [2:0]             WrapCodeLo = 3'd1;

  // m / 125 as (m * 33555) >> 22, exact for any 15-bit m
  localparam logic [15:0] Div125Mul   = 16'd33555;
  localparam int          Div125Shift = 22;

  typedef struct packed {
    logic [ThreshWidth-1:0] sync_min;
    logic [ThreshWidth-1:0] sync_max;
    logic [ThreshWidth-1:0] sweep_min;
    logic [ThreshWidth-1:0] sweep_max;
  } lpwc_cfg_t;

  typedef struct packed {
    logic                 kind;
    logic [TimeWidth-1:0] start_time;
    logic [TimeWidth-1:0] end_time;
  } pulse_info_t;

endpackage

### src/lpwc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpwc_classify
// edge capture, width measurement and window match; first pipeline stage
// ----------------------------------------------------------------------------
`include "light_pulse_width_classifier_top_assert.svh"

module lpwc_classify
  import lpwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  lpwc_cfg_t              cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   edge_level,
  input  logic [TimeWidth-1:0]   edge_time,
  output logic                   s1_valid,
  input  logic                   s1_ready,
  output pulse_info_t            s1_info,
  output logic [ThreshWidth-1:0] s1_width
);

  logic [TimeWidth-1:0] rise_time;
  logic [TimeWidth-1:0] width;
  logic                 in_sync;
  logic                 in_sweep;
  logic                 accept;

  // width with 32-bit wrap and window tests, sync first
  always_comb begin
    width    = edge_time - rise_time;
    in_sync  = (width >= {16'd0, cfg.sync_min}) && (width <= {16'd0, cfg.sync_max});
    in_sweep = (width >= {16'd0, cfg.sweep_min}) && (width <= {16'd0, cfg.sweep_max});
  end

  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;

  // control and rise time
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rise_time <= '0;
    end else if (accept) begin
      s1_valid <= !edge_level && (in_sync || in_sweep);
      if (edge_level) begin
        rise_time <= edge_time;
      end
    end else if (s1_ready) begin
      s1_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info.kind       <= in_sync ? KindSync : KindSweep;
      s1_info.start_time <= rise_time;
      s1_info.end_time   <= edge_time;
      s1_width           <= width[ThreshWidth-1:0];
    end
  end

  `LPWC_ASSERT_NEXT(a_rise_no_result, clk, rst, accept && edge_level && !rst, !s1_valid, "rising edge produced a result")
  `LPWC_ASSERT_NEXT(a_rise_stored, clk, rst, accept && edge_level && !rst, rise_time == $past(edge_time), "rise time not captured")

endmodule

### src/lpwc_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpwc_scale
// scales the sync width to 48 MHz ticks and removes the code offset
// ----------------------------------------------------------------------------
`include "light_pulse_width_classifier_top_assert.svh"

module lpwc_scale
  import lpwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s1_valid,
  output logic                   s1_ready,
  input  pulse_info_t            s1_info,
  input  logic [ThreshWidth-1:0] s1_width,
  output logic                   s2_valid,
  input  logic                   s2_ready,
  output pulse_info_t            s2_info,
  output logic [ScaledWidth-1:0] s2_num,
  output logic                   s2_wrap
);

  logic [31:0]            prod;
  logic [ScaledWidth-1:0] scaled;
  logic                   wrap;
  logic [ScaledWidth-1:0] num;

  // width * 6 / 5 = width + width / 5
  always_comb begin
    prod   = s1_width * Div5Mul;
    scaled = {1'b0, s1_width} + {3'd0, prod[31:Div5Shift]};
    wrap   = scaled < CodeOffset;
    num    = wrap ? (scaled + WrapBias) : (scaled - CodeOffset);
  end

  assign s1_ready = !s2_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2_info <= s1_info;
      s2_num  <= num;
      s2_wrap <= wrap;
    end
  end

  `LPWC_ASSERT_IMPLY(a_wrap_range, clk, rst, s2_valid && s2_info.kind == KindSync && s2_wrap, s2_num < WrapLimit, "wrapped code numerator out of range")

endmodule

### src/lpwc_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpwc_decode
// divides by 500 to get the sync code and holds the result register
// ----------------------------------------------------------------------------
`include "light_pulse_width_classifier_top_assert.svh"

module lpwc_decode
  import lpwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s2_valid,
  output logic                   s2_ready,
  input  pulse_info_t            s2_info,
  input  logic [ScaledWidth-1:0] s2_num,
  input  logic                   s2_wrap,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   pulse_kind,
  output logic [TimeWidth-1:0]   start_time,
  output logic [TimeWidth-1:0]   end_time,
  output logic                   axis_bit,
  output logic                   data_bit,
  output logic                   skip_bit
);

  logic [30:0] prod;
  logic [2:0]  code;

  // num / 500 = (num >> 2) / 125, low three bits kept
  always_comb begin
    prod = s2_num[ScaledWidth-1:2] * Div125Mul;
    code = prod[Div125Shift+2:Div125Shift] + (s2_wrap ? WrapCodeLo : 3'd0);
    if (s2_info.kind == KindSweep) begin
      code = 3'd0;
    end
  end

  assign s2_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s2_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      pulse_kind <= s2_info.kind;
      start_time <= s2_info.start_time;
      end_time   <= s2_info.end_time;
      axis_bit   <= code[0];
      data_bit   <= code[1];
      skip_bit   <= code[2];
    end
  end

  `LPWC_ASSERT_IMPLY(a_sweep_no_code, clk, rst, out_valid && pulse_kind == KindSweep, !axis_bit && !data_bit && !skip_bit, "sweep result carries code bits")

endmodule

### src/light_pulse_width_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_pulse_width_classifier_top
// classifies optical receiver pulses as sync or sweep from edge timestamps
// ----------------------------------------------------------------------------
//   channel  handshake              payload
//   in       in_valid / in_ready    edge_level, edge_time
//   out      out_valid / out_ready  pulse_kind, start_time, end_time,
//                                   axis_bit, data_bit, skip_bit
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one edge event accepted per cycle while in_ready is high; a pulse result is
// registered by the classify, scale and decode stages in turn
// rising edges and widths outside both windows leave no result
// synchronous reset clears the pipeline and rise time, reloads the thresholds
// a stalled output backs up stage by stage; input keeps flowing into empty
// stages; cfg_ready is always high
// ----------------------------------------------------------------------------
module light_pulse_width_classifier_top
  import lpwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [ThreshWidth-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   edge_level,
  input  logic [TimeWidth-1:0]   edge_time,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   pulse_kind,
  output logic [TimeWidth-1:0]   start_time,
  output logic [TimeWidth-1:0]   end_time,
  output logic                   axis_bit,
  output logic                   data_bit,
  output logic                   skip_bit
);

  lpwc_cfg_t              cfg;
  logic                   s1_valid;
  logic                   s1_ready;
  pulse_info_t            s1_info;
  logic [ThreshWidth-1:0] s1_width;
  logic                   s2_valid;
  logic                   s2_ready;
  pulse_info_t            s2_info;
  logic [ScaledWidth-1:0] s2_num;
  logic                   s2_wrap;

  assign cfg_ready = 1'b1;

  // threshold registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_min  <= SyncMinReset;
      cfg.sync_max  <= SyncMaxReset;
      cfg.sweep_min <= SweepMinReset;
      cfg.sweep_max <= SweepMaxReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegSyncMin:  cfg.sync_min  <= cfg_data;
        RegSyncMax:  cfg.sync_max  <= cfg_data;
        RegSweepMin: cfg.sweep_min <= cfg_data;
        RegSweepMax: cfg.sweep_max <= cfg_data;
        default: ;
      endcase
    end
  end

  lpwc_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .edge_level (edge_level),
    .edge_time  (edge_time),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_info    (s1_info),
    .s1_width   (s1_width)
  );

  lpwc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_info  (s1_info),
    .s1_width (s1_width),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_info  (s2_info),
    .s2_num   (s2_num),
    .s2_wrap  (s2_wrap)
  );

  lpwc_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .s2_valid   (s2_valid),
    .s2_ready   (s2_ready),
    .s2_info    (s2_info),
    .s2_num     (s2_num),
    .s2_wrap    (s2_wrap),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pulse_kind (pulse_kind),
    .start_time (start_time),
    .end_time   (end_time),
    .axis_bit   (axis_bit),
    .data_bit   (data_bit),
    .skip_bit   (skip_bit)
  );

endmodule

### test/light_pulse_width_classifier_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_pulse_width_classifier_top_test
// drives edge event transactions into the pulse classifier and checks every
// sync and sweep result against a cycle-free prediction of the pulse width
// windows and sync code decode, over several threshold settings and
// random idling on both the edge and result channels
// ----------------------------------------------------------------------------
module light_pulse_width_classifier_top_test;
  import lpwc_pkg::*;

  // one edge event waiting to be driven
  typedef struct packed {
    logic                 level;
    logic [TimeWidth-1:0] stamp;
  } edge_event_t;

  // one classified pulse, as seen on the result channel
  typedef struct packed {
    logic                 kind;
    logic [TimeWidth-1:0] start_t;
    logic [TimeWidth-1:0] end_t;
    logic                 axis;
    logic                 data;
    logic                 skip;
  } pulse_result_t;

  // sync code decode constants, 32-bit wrapping arithmetic
  localparam logic [31:0] ScaleMul     = 32'd6;
  localparam logic [31:0] ScaleDiv     = 32'd5;
  localparam logic [31:0] SyncCodeBase = 32'd2501;
  localparam logic [31:0] SyncCodeStep = 32'd500;

  // register indexes that select no register
  localparam logic [CfgIdxWidth-1:0] StrayRegIdxLo = 8'd4;
  localparam logic [CfgIdxWidth-1:0] StrayRegIdxHi = 8'hFF;

  localparam int ResetCycles = 11;
  localparam int DrainCycles = 12;
  localparam int CycleLimit  = 200000;
  localparam int ReportLimit = 10;
  localparam int PhaseEdges  = 150;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [ThreshWidth-1:0] cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   edge_level = 1'b0;
  logic [TimeWidth-1:0]   edge_time = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   pulse_kind;
  logic [TimeWidth-1:0]   start_time;
  logic [TimeWidth-1:0]   end_time;
  logic                   axis_bit;
  logic                   data_bit;
  logic                   skip_bit;

  // threshold copy and rise time held by the predictor
  logic [ThreshWidth-1:0] sync_lo;
  logic [ThreshWidth-1:0] sync_hi;
  logic [ThreshWidth-1:0] sweep_lo;
  logic [ThreshWidth-1:0] sweep_hi;
  logic [TimeWidth-1:0]   model_rise_time;

  edge_event_t   pending_edges[$];
  pulse_result_t predicted_pulses[$];
  edge_event_t   next_edge;
  pulse_result_t new_pulse;
  pulse_result_t seen_pulse;
  pulse_result_t want_pulse;

  int edges_queued = 0;
  int edges_taken = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  light_pulse_width_classifier_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .edge_level (edge_level),
    .edge_time  (edge_time),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pulse_kind (pulse_kind),
    .start_time (start_time),
    .end_time   (end_time),
    .axis_bit   (axis_bit),
    .data_bit   (data_bit),
    .skip_bit   (skip_bit)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run time limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("light_pulse_width_classifier_top verification failed");
      $finish;
    end
  end

  // classify one edge event; returns 1 when it yields a pulse
  function automatic bit classify_edge(input logic level, input logic [31:0] stamp,
                                       output pulse_result_t res);
    logic [31:0] width;
    logic [31:0] scaled;
    logic [31:0] code;
    res = '0;
    if (level) begin
      model_rise_time = stamp;
      return 1'b0;
    end
    width = stamp - model_rise_time;
    res.start_t = model_rise_time;
    res.end_t = stamp;
    // sync window takes priority over the sweep window
    if ({16'b0, sync_lo} <= width && width <= {16'b0, sync_hi}) begin
      scaled = (width * ScaleMul) / ScaleDiv;
      code = (scaled - SyncCodeBase) / SyncCodeStep;
      res.kind = KindSync;
      res.axis = code[0];
      res.data = code[1];
      res.skip = code[2];
      return 1'b1;
    end
    if ({16'b0, sweep_lo} <= width && width <= {16'b0, sweep_hi}) begin
      res.kind = KindSweep;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // threshold copy follows register write transactions
  always @(posedge clk) begin
    if (rst) begin
      sync_lo <= SyncMinReset;
      sync_hi <= SyncMaxReset;
      sweep_lo <= SweepMinReset;
      sweep_hi <= SweepMaxReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegSyncMin:  sync_lo <= cfg_data;
        RegSyncMax:  sync_hi <= cfg_data;
        RegSweepMin: sweep_lo <= cfg_data;
        RegSweepMax: sweep_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // edge event driver, predicts on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      edge_level <= 1'b0;
      edge_time <= '0;
      model_rise_time = '0;
    end else begin
      if (in_valid && in_ready) begin
        edges_taken++;
        if (classify_edge(edge_level, edge_time, new_pulse))
          predicted_pulses.push_back(new_pulse);
      end
      if (!in_valid || in_ready) begin
        if (pending_edges.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          next_edge = pending_edges.pop_front();
          in_valid <= 1'b1;
          edge_level <= next_edge.level;
          edge_time <= next_edge.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        seen_pulse = '{pulse_kind, start_time, end_time, axis_bit, data_bit, skip_bit};
        if (predicted_pulses.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("%0t unexpected pulse: kind %0d start %h end %h axis/data/skip %b%b%b",
                     $realtime, seen_pulse.kind, seen_pulse.start_t, seen_pulse.end_t,
                     seen_pulse.axis, seen_pulse.data, seen_pulse.skip);
        end else begin
          want_pulse = predicted_pulses.pop_front();
          if (seen_pulse.kind !== want_pulse.kind || seen_pulse.start_t !== want_pulse.start_t ||
              seen_pulse.end_t !== want_pulse.end_t || seen_pulse.axis !== want_pulse.axis ||
              seen_pulse.data !== want_pulse.data || seen_pulse.skip !== want_pulse.skip) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
              $display("%0t pulse mismatch: expected kind %0d start %h end %h bits %b%b%b",
                       $realtime, want_pulse.kind, want_pulse.start_t, want_pulse.end_t,
                       want_pulse.axis, want_pulse.data, want_pulse.skip);
              $display("%0t                 actual   kind %0d start %h end %h bits %b%b%b",
                       $realtime, seen_pulse.kind, seen_pulse.start_t, seen_pulse.end_t,
                       seen_pulse.axis, seen_pulse.data, seen_pulse.skip);
            end
          end
        end
      end
    end
  end

  task automatic add_edge(input logic level, input logic [31:0] stamp);
    pending_edges.push_back('{level, stamp});
    edges_queued++;
  endtask

  // pulse width aimed at the windows and their borders
  function automatic logic [31:0] pick_width();
    logic [31:0] a_lo;
    logic [31:0] a_hi;
    logic [31:0] b_lo;
    logic [31:0] b_hi;
    int sel;
    a_lo = {16'b0, sync_lo};
    a_hi = {16'b0, sync_hi};
    b_lo = {16'b0, sweep_lo};
    b_hi = {16'b0, sweep_hi};
    sel = $urandom_range(13, 0);
    case (sel)
      0, 1, 2: return $urandom_range(a_hi, a_lo);
      3, 4, 5: return $urandom_range(b_hi, b_lo);
      6:       return a_lo - 1;
      7:       return a_hi + 1;
      8:       return b_lo - 1;
      9:       return b_hi + 1;
      10:      return $urandom_range(1, 0) ? a_lo : a_hi;
      11:      return $urandom_range(1, 0) ? b_lo : b_hi;
      12:      return $urandom_range(65535, 0);
      default: return $urandom;
    endcase
  endfunction

  // mostly rise/fall pairs, some repeated edges and loose noise
  task automatic add_random_edges(input int count);
    int n;
    int shape;
    logic [31:0] t0;
    n = 0;
    while (n < count) begin
      shape = $urandom_range(99, 0);
      t0 = $urandom;
      if (shape < 70) begin
        add_edge(1'b1, t0);
        add_edge(1'b0, t0 + pick_width());
        n += 2;
        if ($urandom_range(5, 0) == 0) begin
          add_edge(1'b0, t0 + pick_width());
          n++;
        end
      end else if (shape < 85) begin
        add_edge(1'b1, $urandom);
        add_edge(1'b1, t0);
        add_edge(1'b0, t0 + pick_width());
        n += 3;
      end else begin
        add_edge(1'($urandom_range(1, 0)), t0);
        n++;
      end
    end
  endtask

  // wait for all transactions and results, then let the pipeline empty
  task automatic wait_drained();
    do @(posedge clk);
    while (edges_taken != edges_queued || predicted_pulses.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no second assignment
  task automatic write_threshold(input logic [CfgIdxWidth-1:0] idx,
                                 input logic [ThreshWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
  endtask

  task automatic run_phase(input logic [15:0] s_lo, input logic [15:0] s_hi,
                           input logic [15:0] w_lo, input logic [15:0] w_hi,
                           input bit stray_writes);
    write_threshold(RegSyncMin, s_lo);
    write_threshold(RegSyncMax, s_hi);
    write_threshold(RegSweepMin, w_lo);
    write_threshold(RegSweepMax, w_hi);
    if (stray_writes) begin
      write_threshold(StrayRegIdxLo, 16'hFFFF);
      write_threshold(StrayRegIdxHi, 16'h0000);
    end
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
    add_random_edges(PhaseEdges);
    wait_drained();
  endtask

  // stimulus sequence
  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 26;
    recv_idle_pct = 74;
    @(posedge clk);

    // falling edge before any rising edge, measured from zero
    add_edge(1'b0, 32'd3000);
    // window borders under reset thresholds, width wrapping past zero
    add_edge(1'b1, 32'hFFFF_FF00);
    add_edge(1'b0, 32'hFFFF_FF00 + 32'd2400);
    add_edge(1'b0, 32'hFFFF_FF00 + 32'd5600);
    add_edge(1'b0, 32'hFFFF_FF00 + 32'd5601);
    add_edge(1'b0, 32'hFFFF_FF00 + 32'd2399);
    add_edge(1'b1, 32'h0000_0000);
    add_edge(1'b0, 32'd40);
    add_edge(1'b0, 32'd800);
    add_edge(1'b0, 32'd39);
    add_edge(1'b0, 32'd801);
    // latest rising edge wins
    add_edge(1'b1, 32'h1234_5678);
    add_edge(1'b1, 32'h8000_0000);
    add_edge(1'b0, 32'h8000_0000 + 32'd100);
    // all-ones stamp, then zero width
    add_edge(1'b1, 32'hFFFF_FFFF);
    add_edge(1'b0, 32'hFFFF_FFFF + 32'd500);
    add_edge(1'b0, 32'hFFFF_FFFF);
    // sync widths spread over the code values
    add_edge(1'b1, 32'hAAAA_AAAA);
    add_edge(1'b0, 32'hAAAA_AAAA + 32'd2900);
    add_edge(1'b0, 32'hAAAA_AAAA + 32'd3300);
    add_edge(1'b0, 32'hAAAA_AAAA + 32'd3750);
    add_edge(1'b0, 32'hAAAA_AAAA + 32'd4200);
    add_edge(1'b0, 32'hAAAA_AAAA + 32'd4600);
    add_edge(1'b0, 32'hAAAA_AAAA + 32'd5000);
    add_edge(1'b0, 32'hAAAA_AAAA + 32'd5500);
    wait_drained();

    // reset thresholds, then full-range overlapping windows
    add_random_edges(PhaseEdges);
    wait_drained();
    run_phase(16'd0, 16'd65535, 16'd0, 16'd65535, 1'b0);
    // empty sync window, stray register writes
    run_phase(16'd5000, 16'd1000, 16'd0, 16'd1000, 1'b1);

    send_idle_pct = 74;
    recv_idle_pct = 26;
    // top single-point sync window, empty sweep window
    run_phase(16'd65535, 16'd65535, 16'd65535, 16'd0, 1'b0);
    // sweep window overlapping the low end of the sync window
    run_phase(16'd100, 16'd9000, 16'd50, 16'd200, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // single-point windows
    run_phase(16'd3000, 16'd3000, 16'd0, 16'd0, 1'b0);
    run_phase(SyncMinReset, SyncMaxReset, SweepMinReset, SweepMaxReset, 1'b0);

    if (mismatch_count == 0) begin
      $display("light_pulse_width_classifier_top verification clean");
    end else begin
      $display("light_pulse_width_classifier_top verification failed");
    end
    $finish;
  end

endmodule
